FILE: hdl/text_console_writer_core_defines.svh
// Assertion macros for the checker file of the text console writer.
// Depends on nothing; included by bare file name.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_HOLDS(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
// Package of the text console writer: field types, codes and defaults.
// Depends on nothing; used by the ring, the core and the checker.
`default_nettype none

package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int CELL_IDX_W = 11;
	localparam int BYTE_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int WORD_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_BASE   = 1'd1;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
	localparam logic [WORD_W-1:0] BASE_RESET   = 16'h0800;

	typedef struct packed {
		logic [1:0]            func;
		logic [BYTE_W-1:0]     text_byte;
		logic                  end_of_text;
		logic [CELL_IDX_W-1:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] cursor_location;
		logic [WORD_W-1:0] cell_word;
		logic              dropped;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_FILL
	} state_t;

	typedef struct packed {
		logic scroll;
		logic home;
	} ring_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/tcw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/tcw_ring.sv
// Row ring of the frame store: maps logical cells to physical addresses.
// Depends on tcw_pkg. Scrolling moves the top row pointer instead of copying.
`default_nettype none

module tcw_ring #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire tcw_pkg::ring_ctl_t                      ctl,
	input  wire logic [tcw_pkg::CELL_IDX_W-1:0]          cell_index,
	input  wire logic [$clog2(COLUMNS+1)-1:0]            column,
	output logic      [$clog2(ROWS*COLUMNS)-1:0]         rd_addr,
	output logic                                         rd_in_range,
	output logic      [$clog2(ROWS*COLUMNS)-1:0]         wr_addr,
	output logic      [$clog2(ROWS*COLUMNS)-1:0]         top_base
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = ((AW > tcw_pkg::CELL_IDX_W) ? AW : tcw_pkg::CELL_IDX_W) + 1;

	logic [AW-1:0] top_base_q;
	logic [AW-1:0] bottom_base_q;
	logic [XW-1:0] idx_x;
	logic [XW-1:0] sum_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_base_q    <= '0;
			bottom_base_q <= AW'(CELLS - COLUMNS);
		end else if (ctl.home) begin
			top_base_q    <= '0;
			bottom_base_q <= AW'(CELLS - COLUMNS);
		end else if (ctl.scroll) begin
			// The old top row becomes the new bottom row.
			bottom_base_q <= top_base_q;
			if (top_base_q == AW'(CELLS - COLUMNS)) begin
				top_base_q <= '0;
			end else begin
				top_base_q <= top_base_q + AW'(COLUMNS);
			end
		end
	end

	always_comb begin
		idx_x       = XW'(cell_index);
		rd_in_range = idx_x < XW'(CELLS);
		sum_x       = idx_x + XW'(top_base_q);
		if (sum_x >= XW'(CELLS)) begin
			rd_addr = AW'(sum_x - XW'(CELLS));
		end else begin
			rd_addr = AW'(sum_x);
		end
	end

	assign wr_addr  = bottom_base_q + AW'(column);
	assign top_base = top_base_q;

endmodule

`default_nettype wire

FILE: hdl/text_console_writer_core.sv
// Text console writer: bottom-line writer over a ring-organized frame store.
// Write byte: result in the cycle after acceptance, one byte per cycle unless stalled or busy.
// Read cell: result via the registered RAM read, then the output register; no request taken meanwhile.
// Newline: busy while the new bottom row is blanked; clear: busy while the whole store is blanked.
// Reset: a sweep blanks all ROWS*COLUMNS cells (2000 by default), req_ready held low.
`default_nettype none

module text_console_writer_core #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire tcw_pkg::req_t                    req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output tcw_pkg::rsp_t                         rsp
);

	// The frame store is one RAM of ROWS*COLUMNS cells. Logical rows live in a
	// ring: a newline advances the top row pointer by one row and only the row
	// that wraps around to the bottom is blanked, so a scroll writes only COLUMNS
	// cells instead of a full-screen copy. Blanking is a sweep of the
	// RAM write port driven by the fill address and count registers below.

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CLW   = $clog2(COLUMNS + 1);
	localparam int FW    = $clog2(CELLS + 1);
	localparam logic [tcw_pkg::WORD_W-1:0] BOTTOM_OFS = tcw_pkg::WORD_W'((ROWS - 1) * COLUMNS);

	tcw_pkg::state_t    state_q, state_d;
	tcw_pkg::ring_ctl_t ring_ctl;
	tcw_pkg::rsp_t      rsp_q, rsp_d;

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic [tcw_pkg::WORD_W-1:0] base_q;
	logic [tcw_pkg::WORD_W-1:0] cursor_q;
	logic [tcw_pkg::WORD_W-1:0] cursor_calc;
	logic [CLW-1:0]             column_q;
	logic [CLW-1:0]             col_next;
	logic [AW-1:0]              fill_addr_q, fill_addr_d;
	logic [FW-1:0]              fill_left_q, fill_len;
	logic [tcw_pkg::WORD_W-1:0] fill_word_q;
	logic                       fill_start;
	logic                       rsp_valid_q;
	logic                       rsp_load;
	logic                       rd_in_range_q;

	logic                       accept;
	logic                       is_newline;
	logic                       line_full;

	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [tcw_pkg::WORD_W-1:0] mem_wdata;
	logic [tcw_pkg::WORD_W-1:0] mem_rdata;
	logic [AW-1:0]              rd_addr;
	logic                       rd_in_range;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              top_base;

	tcw_ring #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ring_ctl),
		.cell_index  (req.cell_index),
		.column      (column_q),
		.rd_addr     (rd_addr),
		.rd_in_range (rd_in_range),
		.wr_addr     (wr_addr),
		.top_base    (top_base)
	);

	tcw_ram #(
		.WIDTH (tcw_pkg::WORD_W),
		.DEPTH (CELLS)
	) u_frame_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (mem_rdata)
	);

	assign accept     = req_valid && req_ready;
	assign is_newline = req.text_byte == tcw_pkg::NEWLINE_CODE;
	assign line_full  = column_q == CLW'(COLUMNS);

	// Column after a write transaction. A full line keeps its column, so
	// a later end mark puts the cursor just past the last cell.
	always_comb begin
		if (is_newline) begin
			col_next = '0;
		end else if (!line_full) begin
			col_next = column_q + CLW'(1);
		end else begin
			col_next = column_q;
		end
		cursor_calc = base_q + BOTTOM_OFS + tcw_pkg::WORD_W'(col_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM write port, ring control and the result to load.
	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		ring_ctl    = '0;
		mem_we      = 1'b0;
		mem_waddr   = fill_addr_q;
		mem_wdata   = fill_word_q;
		fill_start  = 1'b0;
		fill_addr_d = '0;
		fill_len    = FW'(CELLS);
		rsp_load    = 1'b0;
		rsp_d       = '0;
		rsp_d.cursor_location = cursor_q;
		case (state_q)
			tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
				mem_we = 1'b1;
				if (fill_left_q == FW'(1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				// The output register may be refilled in the cycle it is taken.
				req_ready = !rsp_valid_q || rsp_ready;
				if (accept) begin
					case (req.func)
						tcw_pkg::FUNC_WRITE: begin
							rsp_load = 1'b1;
							if (req.end_of_text) begin
								rsp_d.cursor_location = cursor_calc;
							end
							if (is_newline) begin
								ring_ctl.scroll = 1'b1;
								fill_start      = 1'b1;
								fill_addr_d     = top_base;
								fill_len        = FW'(COLUMNS);
								state_d         = tcw_pkg::ST_FILL;
							end else if (!line_full) begin
								mem_we    = 1'b1;
								mem_waddr = wr_addr;
								mem_wdata = {attr_q, req.text_byte};
							end else begin
								rsp_d.dropped = 1'b1;
							end
						end
						tcw_pkg::FUNC_CLEAR: begin
							rsp_load      = 1'b1;
							ring_ctl.home = 1'b1;
							fill_start    = 1'b1;
							state_d       = tcw_pkg::ST_FILL;
						end
						tcw_pkg::FUNC_READ: begin
							state_d = tcw_pkg::ST_READ;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			tcw_pkg::ST_READ: begin
				rsp_load = 1'b1;
				if (rd_in_range_q) begin
					rsp_d.cell_word = mem_rdata;
				end
				state_d = tcw_pkg::ST_IDLE;
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
			base_q <= tcw_pkg::BASE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				tcw_pkg::REG_TEXT_ATTRIBUTE: attr_q <= cfg_data[tcw_pkg::ATTR_W-1:0];
				tcw_pkg::REG_DISPLAY_BASE:   base_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Column and shown cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			cursor_q <= tcw_pkg::BASE_RESET + BOTTOM_OFS;
		end else if (accept) begin
			if (req.func == tcw_pkg::FUNC_WRITE) begin
				column_q <= col_next;
				if (req.end_of_text) begin
					cursor_q <= cursor_calc;
				end
			end else if (req.func == tcw_pkg::FUNC_CLEAR) begin
				column_q <= '0;
			end
		end
	end

	// Blanking sweep. After reset it uses the reset attribute; later sweeps
	// take the attribute in force when the transaction is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_addr_q <= '0;
			fill_left_q <= FW'(CELLS);
			fill_word_q <= {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CODE};
		end else if (fill_start) begin
			fill_addr_q <= fill_addr_d;
			fill_left_q <= fill_len;
			fill_word_q <= {attr_q, tcw_pkg::SPACE_CODE};
		end else if (mem_we && (state_q != tcw_pkg::ST_IDLE)) begin
			fill_addr_q <= fill_addr_q + AW'(1);
			fill_left_q <= fill_left_q - FW'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (accept) begin
			rd_in_range_q <= rd_in_range;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: hdl/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_core_defines.svh.
`default_nettype none
`include "text_console_writer_core_defines.svh"

module tcw_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire tcw_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire tcw_pkg::rsp_t rsp
);

	`TCW_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

	`TCW_ASSERT_HOLDS(a_no_overrun, clk, arst_n, req_ready && rsp_valid, rsp_ready, "transaction taken while result stalled")

	`TCW_ASSERT_NEXT(a_write_result, clk, arst_n, req_valid && req_ready && req.func == tcw_pkg::FUNC_WRITE, rsp_valid && rsp.cell_word == '0, "write transaction gave no clean result")

	`TCW_ASSERT_NEXT(a_scroll_busy, clk, arst_n, req_valid && req_ready && req.func == tcw_pkg::FUNC_WRITE && req.text_byte == tcw_pkg::NEWLINE_CODE, !req_ready, "ready during row blanking")

	`TCW_ASSERT_HOLDS(a_drop_clean, clk, arst_n, rsp_valid && rsp.dropped, rsp.cell_word == '0, "dropped byte carried cell data")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

`default_nettype wire
